>>> rtl/core/ctp_pkg.sv
// Package for the countdown timer pool: command and slot-state codes, the
// slot entry layout, controller states and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctp_pkg;

  // Field widths fixed by the interface
  localparam int CmdW      = 3;
  localparam int SlotIdW   = 3;
  localparam int CountW    = 16;
  // Slots that a slot_id can address
  localparam int AddrSlots = 8;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK  = 3'd0,
    CMD_ALLOC = 3'd1,
    CMD_START = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_FREE  = 3'd4,
    CMD_QUERY = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_STOPPED  = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_FINISHED = 2'd3
  } slot_state_e;

  // One slot as held in the slot memory
  typedef struct packed {
    slot_state_e       st;
    logic [CountW-1:0] cnt;
  } entry_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_TICK,
    FSM_ALLOC,
    FSM_WRITE,
    FSM_QREAD,
    FSM_QEVAL,
    FSM_DONE
  } fsm_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // latch the accepted transaction
    logic idx_inc;    // advance the sweep index
    logic rd_en;      // read the slot memory
    logic rd_slot;    // read at slot_id rather than at the sweep index
    logic tick_wb;    // write back the tick update of the returned entry
    logic alloc_chk;  // claim the returned entry if it is free
    logic direct_wr;  // apply start, stop or free to the addressed slot
    logic query_chk;  // capture the query answer from the returned entry
    logic res_load;   // move the result into the output register
  } ctrl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic sweep_end;   // every slot has been read
    logic search_end;  // every allocatable slot has been read
    logic alloc_hit;   // returned entry is free
    logic out_free;    // output register can take a result
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/core/ctp_dpath.sv
// Datapath of the countdown timer pool: slot memory with per-slot valid
// bits, sweep index, transaction and result registers, output register.
// Depends on ctp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctp_dpath #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [ctp_pkg::CmdW-1:0]       cmd_i,
  input  logic [ctp_pkg::SlotIdW-1:0]    slot_id_i,
  input  logic [ctp_pkg::CountW-1:0]     duration_ms_i,
  input  logic                           out_ready_i,
  input  ctp_pkg::ctrl_t                 ctrl_i,
  output ctp_pkg::stat_t                 stat_o,
  output logic                           out_valid_o,
  output logic                           ok_o,
  output logic [ctp_pkg::SlotIdW-1:0]    granted_slot_o,
  output logic                           finished_o
);

  localparam int IW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW  = $clog2(NUM_SLOTS + 1);
  localparam int SW  = (IW > ctp_pkg::SlotIdW) ? IW : ctp_pkg::SlotIdW;
  localparam int LIM = (NUM_SLOTS < ctp_pkg::AddrSlots) ? NUM_SLOTS : ctp_pkg::AddrSlots;

  logic [ctp_pkg::CmdW-1:0]    cmd_q;
  logic [ctp_pkg::SlotIdW-1:0] slot_q;
  logic [ctp_pkg::CountW-1:0]  dur_q;

  logic [CW-1:0]           idx_q;
  logic [NUM_SLOTS-1:0]    valid_q;
  ctp_pkg::entry_t         mem_q [NUM_SLOTS];
  ctp_pkg::entry_t         rd_data_q;
  logic                    rd_vld_q;
  logic                    rd_pend_q;
  logic [IW-1:0]           rd_addr_q;

  logic                        res_ok_q, res_fin_q;
  logic [ctp_pkg::SlotIdW-1:0] res_grant_q;
  logic                        out_valid_q, out_ok_q, out_fin_q;
  logic [ctp_pkg::SlotIdW-1:0] out_grant_q;

  logic [SW-1:0]   slot_ext;
  logic [SW-1:0]   ridx_ext;
  logic [IW-1:0]   slot_addr;
  logic            slot_ok;
  logic [IW-1:0]   rd_addr;
  ctp_pkg::entry_t entry;
  logic            alloc_hit;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  ctp_pkg::entry_t wr_data;
  logic            out_free;

  // Map the slot id and the returned index between address widths
  assign slot_ext  = SW'(slot_q);
  assign slot_addr = slot_ext[IW-1:0];
  assign slot_ok   = (32'(slot_q) < NUM_SLOTS);
  assign ridx_ext  = SW'(rd_addr_q);

  assign rd_addr   = ctrl_i.rd_slot ? slot_addr : idx_q[IW-1:0];
  // A slot never written reads as free with a zero count
  assign entry     = rd_vld_q ? rd_data_q : ctp_pkg::entry_t'('0);
  assign alloc_hit = rd_pend_q && (entry.st == ctp_pkg::ST_FREE);
  assign out_free  = !out_valid_q || out_ready_i;

  // Latch the accepted transaction
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= cmd_i;
      slot_q <= slot_id_i;
      dur_q  <= duration_ms_i;
    end
  end

  // Sweep index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (ctrl_i.load) begin
      idx_q <= '0;
    end else if (ctrl_i.idx_inc) begin
      idx_q <= idx_q + CW'(1);
    end
  end

  // Select the write-back for tick, allocate and the direct commands
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr_q;
    wr_data = entry;
    if (ctrl_i.tick_wb && rd_pend_q && (entry.st == ctp_pkg::ST_RUNNING)) begin
      wr_en = 1'b1;
      if (entry.cnt != '0) begin
        wr_data.cnt = entry.cnt - ctp_pkg::CountW'(1);
      end else begin
        wr_data.st = ctp_pkg::ST_FINISHED;
      end
    end
    if (ctrl_i.alloc_chk && alloc_hit) begin
      wr_en   = 1'b1;
      wr_data = '{st: ctp_pkg::ST_STOPPED, cnt: '0};
    end
    if (ctrl_i.direct_wr && slot_ok) begin
      wr_addr = slot_addr;
      case (cmd_q)
        ctp_pkg::CMD_START: begin
          wr_en   = 1'b1;
          wr_data = '{st: ctp_pkg::ST_RUNNING, cnt: dur_q};
        end
        ctp_pkg::CMD_STOP: begin
          wr_en   = 1'b1;
          wr_data = '{st: ctp_pkg::ST_STOPPED, cnt: '0};
        end
        ctp_pkg::CMD_FREE: begin
          wr_en   = 1'b1;
          wr_data = '{st: ctp_pkg::ST_FREE, cnt: '0};
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // Slot memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // Valid bits stand in for the reset value of every slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rd_vld_q  <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_vld_q <= valid_q[rd_addr];
      end
      rd_pend_q <= ctrl_i.rd_en;
    end
  end

  // Build the result of the transaction
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      res_ok_q    <= (cmd_i != ctp_pkg::CMD_ALLOC);
      res_grant_q <= '0;
      res_fin_q   <= 1'b0;
    end else begin
      if (ctrl_i.alloc_chk && alloc_hit) begin
        res_ok_q    <= 1'b1;
        res_grant_q <= ridx_ext[ctp_pkg::SlotIdW-1:0];
      end
      if (ctrl_i.query_chk) begin
        res_fin_q <= slot_ok && (entry.st == ctp_pkg::ST_FINISHED);
      end
    end
  end

  // Output register: hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_load) begin
      out_ok_q    <= res_ok_q;
      out_grant_q <= res_grant_q;
      out_fin_q   <= res_fin_q;
    end
  end

  assign stat_o.sweep_end  = (idx_q == CW'(NUM_SLOTS));
  assign stat_o.search_end = (idx_q == CW'(LIM));
  assign stat_o.alloc_hit  = alloc_hit;
  assign stat_o.out_free   = out_free;

  assign out_valid_o    = out_valid_q;
  assign ok_o           = out_ok_q;
  assign granted_slot_o = out_grant_q;
  assign finished_o     = out_fin_q;

endmodule

`default_nettype wire

>>> rtl/core/ctp_ctrl.sv
// Controller of the countdown timer pool: state machine that sequences
// each transaction over the slot memory. Depends on ctp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctp_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [ctp_pkg::CmdW-1:0] cmd_i,
  output logic                     in_ready_o,
  input  ctp_pkg::stat_t           stat_i,
  output ctp_pkg::ctrl_t           ctrl_o
);

  ctp_pkg::fsm_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctp_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ctp_pkg::FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          case (cmd_i)
            ctp_pkg::CMD_TICK:  state_d = ctp_pkg::FSM_TICK;
            ctp_pkg::CMD_ALLOC: state_d = ctp_pkg::FSM_ALLOC;
            ctp_pkg::CMD_START,
            ctp_pkg::CMD_STOP,
            ctp_pkg::CMD_FREE:  state_d = ctp_pkg::FSM_WRITE;
            ctp_pkg::CMD_QUERY: state_d = ctp_pkg::FSM_QREAD;
            default:            state_d = ctp_pkg::FSM_DONE;
          endcase
        end
      end
      // Read one slot a cycle, write back the one read the cycle before
      ctp_pkg::FSM_TICK: begin
        ctrl_o.tick_wb = 1'b1;
        ctrl_o.rd_en   = !stat_i.sweep_end;
        ctrl_o.idx_inc = !stat_i.sweep_end;
        if (stat_i.sweep_end) begin
          state_d = ctp_pkg::FSM_DONE;
        end
      end
      // Search upwards and stop at the first free slot or after the last allocatable one
      ctp_pkg::FSM_ALLOC: begin
        ctrl_o.alloc_chk = 1'b1;
        ctrl_o.rd_en     = !stat_i.search_end;
        ctrl_o.idx_inc   = !stat_i.search_end;
        if (stat_i.alloc_hit || stat_i.search_end) begin
          state_d = ctp_pkg::FSM_DONE;
        end
      end
      ctp_pkg::FSM_WRITE: begin
        ctrl_o.direct_wr = 1'b1;
        state_d          = ctp_pkg::FSM_DONE;
      end
      ctp_pkg::FSM_QREAD: begin
        ctrl_o.rd_en   = 1'b1;
        ctrl_o.rd_slot = 1'b1;
        state_d        = ctp_pkg::FSM_QEVAL;
      end
      ctp_pkg::FSM_QEVAL: begin
        ctrl_o.query_chk = 1'b1;
        state_d          = ctp_pkg::FSM_DONE;
      end
      // Hand the result over once the output register is free
      ctp_pkg::FSM_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.res_load = 1'b1;
          state_d         = ctp_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = ctp_pkg::FSM_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/countdown_timer_pool.sv
// Top level of the countdown timer pool: controller plus datapath.
// Depends on ctp_pkg, ctp_ctrl and ctp_dpath.
`timescale 1ns / 1ps
`default_nettype none

// A pool of NUM_SLOTS countdown timers held in a slot memory with one read
// and one write port, one transaction at a time, exactly one result per
// transaction. The slot memory is read one entry a cycle: a tick reads all
// NUM_SLOTS slots, an allocate up to min(NUM_SLOTS, 8), a query one; start,
// stop and free write the addressed slot if it exists, and an unused code
// only returns a result. Results wait in an output register, so a new
// transaction is accepted while the previous result is still pending.
// Per-slot valid bits give every slot its reset state (free, count zero)
// at once, so no clearing pass follows reset.
module countdown_timer_pool #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ctp_pkg::CmdW-1:0]    cmd_i,
  input  logic [ctp_pkg::SlotIdW-1:0] slot_id_i,
  input  logic [ctp_pkg::CountW-1:0]  duration_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        ok_o,
  output logic [ctp_pkg::SlotIdW-1:0] granted_slot_o,
  output logic                        finished_o
);

  ctp_pkg::ctrl_t ctrl;
  ctp_pkg::stat_t stat;

  ctp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ctp_dpath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .slot_id_i      (slot_id_i),
    .duration_ms_i  (duration_ms_i),
    .out_ready_i    (out_ready_i),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .ok_o           (ok_o),
    .granted_slot_o (granted_slot_o),
    .finished_o     (finished_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/ctp_checker.sv
// Port-level checks for the countdown timer pool, bound to the top level.
// Depends on ctp_pkg and countdown_timer_pool.
`timescale 1ns / 1ps
`default_nettype none

module ctp_checker #(
  parameter int NUM_SLOTS = 8
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        ok_o,
  input logic [ctp_pkg::SlotIdW-1:0] granted_slot_o,
  input logic                        finished_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ok_o)
      && $stable(granted_slot_o) && $stable(finished_o))
    else $error("result changed while stalled");

  // Take no second transaction straight after one is accepted
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("transaction accepted on consecutive cycles");

  // A failed allocate grants nothing
  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> granted_slot_o == '0 && !finished_o)
    else $error("failed allocate reports a slot");

  // A query answer carries no grant
  a_fin_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> ok_o && granted_slot_o == '0)
    else $error("query answer mixed with a grant");

  // Grant only slots that exist
  a_grant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(granted_slot_o) < NUM_SLOTS)
    else $error("granted slot beyond the pool");

endmodule

bind countdown_timer_pool ctp_checker #(
  .NUM_SLOTS (NUM_SLOTS)
) u_ctp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .ok_o           (ok_o),
  .granted_slot_o (granted_slot_o),
  .finished_o     (finished_o)
);

`default_nettype wire
